// ===== hw/rtl/bba_pkg.sv =====
// Shared constants, codes and bit-order helper for the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int BBA_MAX_BLOCKS = 65536;
  localparam int BBA_WORD_BITS  = 64;

  localparam int CFG_W    = 17;
  localparam int BLK_W    = 16;
  localparam int CNT_W    = 17;
  localparam int ACT_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [CNT_W-1:0] TOTAL_RST = 17'h10000;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INIT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FREE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  // config register indexes
  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_FIRST = 1'b1;

  // Block offset within a word -> bit position; MSB of each byte comes first.
  function automatic int unsigned bit_pos(input int unsigned off);
    return (off & ~32'd7) | (32'd7 - (off & 32'd7));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// Simple dual-port bitmap memory with registered read data.
`default_nettype none

module bba_ram #(
  parameter int DEPTH = bba_pkg::BBA_MAX_BLOCKS / bba_pkg::BBA_WORD_BITS,
  parameter int WIDTH = bba_pkg::BBA_WORD_BITS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ffz.sv =====
// Find the lowest clear block of one bitmap word inside an offset window.
`default_nettype none

module bba_ffz #(
  parameter int WORD_BITS = bba_pkg::BBA_WORD_BITS,
  localparam int LW       = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0] word_i,
  input  wire logic [LW-1:0]        lo_off_i,
  input  wire logic [LW-1:0]        hi_off_i,
  output logic                      found_o,
  output logic      [LW-1:0]        offset_o
);

  always_comb begin
    found_o  = 1'b0;
    offset_o = '0;
    // walk down so the lowest eligible offset wins
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if ((LW'(j) >= lo_off_i) && (LW'(j) <= hi_off_i) &&
          !word_i[LW'(bba_pkg::bit_pos(32'(j)))]) begin
        found_o  = 1'b1;
        offset_o = LW'(j);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Top level of the free-block bitmap allocator: control sequencer and counters.
`default_nettype none

// Bitmap block allocator. One bit per block, set = in use, MSB of each byte first.
// Command channel: an item (action_i, block_index_i, bit_value_i) is taken at a
// clock edge with start high and busy low. Every item gives exactly one result,
// shown for one cycle with done_o high (status_o, result_block_o, bit_read_o,
// free_blocks_o); the receiver has no way to stall it.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 total blocks,
// 1 first data block) at once; write only while no item is in progress.
// Steps per item, from accept edge to result:
//   out-of-range, unknown action, allocate with a zero free count or with no
//   data block below the usable size: result registered at the accept edge
//   free / read bit / write bit: memory read, then modify/write
//   allocate: words scanned one bitmap word per cycle through the
//     single read port, at most MAX_BLOCKS/WORD_BITS words
//   init: one word cleared per cycle over all MAX_BLOCKS/WORD_BITS words
// The next item may be started in the cycle its predecessor's result shows.
// Reset: config returns to 65536 / 0, free count to zero, and the block runs a
// clearing pass over all MAX_BLOCKS/WORD_BITS words with busy high before it
// takes the first item.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::BBA_WORD_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bba_pkg::ACT_W-1:0]      action_i,
  input  wire logic [bba_pkg::BLK_W-1:0]      block_index_i,
  input  wire logic                           bit_value_i,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic      [bba_pkg::STATUS_W-1:0]   status_o,
  output logic      [bba_pkg::BLK_W-1:0]      result_block_o,
  output logic                                bit_read_o,
  output logic      [bba_pkg::CNT_W-1:0]      free_blocks_o
);

  localparam int NWORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LW     = $clog2(WORD_BITS);
  localparam int CW     = bba_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_BIT_RD,
    ST_BIT_OP
  } state_e;

  state_e                       state_q;
  logic [AW-1:0]                clr_q;
  logic                         init_q;
  logic [CW-1:0]                total_q;
  logic [bba_pkg::BLK_W-1:0]    fdb_q;
  logic [CW-1:0]                cnt_q;
  logic [bba_pkg::ACT_W-1:0]    act_q;
  logic [bba_pkg::BLK_W-1:0]    idx_q;
  logic                         bv_q;
  logic [AW-1:0]                bit_addr_q;
  logic [LW-1:0]                bit_off_q;
  logic [AW-1:0]                rd_ptr_q;
  logic [AW-1:0]                chk_addr_q;
  logic                         chk_vld_q;
  logic                         done_q;
  logic [bba_pkg::STATUS_W-1:0] status_q;
  logic [bba_pkg::BLK_W-1:0]    res_q;
  logic                         rdbit_q;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bba_pkg::TOTAL_RST;
      fdb_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bba_pkg::CFG_TOTAL: total_q <= cfg_data_i;
        bba_pkg::CFG_FIRST: fdb_q   <= cfg_data_i[bba_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived bounds
  // ---------------------------------------------------------------------------
  logic [CW-1:0] size;
  logic [CW-1:0] size_m1;
  logic [31:0]   fdb_ext;
  logic [31:0]   last_ext;
  logic [31:0]   idx_ext;
  logic [AW-1:0] lo_w;
  logic [AW-1:0] hi_w;
  logic [LW-1:0] lo_off;
  logic [LW-1:0] hi_off;
  logic          has_room;
  logic          in_range;

  always_comb begin
    // usable size is the smaller of total_blocks and MAX_BLOCKS
    size     = (32'(total_q) < 32'(MAX_BLOCKS)) ? total_q : CW'(MAX_BLOCKS);
    size_m1  = size - CW'(1);
    fdb_ext  = 32'(fdb_q);
    last_ext = 32'(size_m1);
    idx_ext  = 32'(block_index_i);
    lo_w     = fdb_ext[LW +: AW];
    hi_w     = last_ext[LW +: AW];
    lo_off   = fdb_ext[LW-1:0];
    hi_off   = last_ext[LW-1:0];
    has_room = size > CW'(fdb_q);
    in_range = CW'(block_index_i) < size;
  end

  // ---------------------------------------------------------------------------
  // Bitmap memory and word search
  // ---------------------------------------------------------------------------
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  bba_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic [LW-1:0] win_lo;
  logic [LW-1:0] win_hi;
  logic          ffz_found;
  logic [LW-1:0] ffz_off;

  // window edges only apply to the first and last word of the data range
  assign win_lo = (chk_addr_q == lo_w) ? lo_off : '0;
  assign win_hi = (chk_addr_q == hi_w) ? hi_off : '1;

  bba_ffz #(
    .WORD_BITS (WORD_BITS)
  ) u_ffz (
    .word_i   (mem_rdata),
    .lo_off_i (win_lo),
    .hi_off_i (win_hi),
    .found_o  (ffz_found),
    .offset_o (ffz_off)
  );

  logic [WORD_BITS-1:0] one_w;
  logic [WORD_BITS-1:0] alloc_mask;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 cur_bit;
  logic [31:0]          alloc_blk;

  always_comb begin
    one_w      = {{(WORD_BITS-1){1'b0}}, 1'b1};
    alloc_mask = one_w << LW'(bba_pkg::bit_pos(32'(ffz_off)));
    bit_mask   = one_w << LW'(bba_pkg::bit_pos(32'(bit_off_q)));
    cur_bit    = |(mem_rdata & bit_mask);
    alloc_blk  = (32'(chk_addr_q) << LW) | 32'(ffz_off);
  end

  // memory port steering; a write never lands on a word whose read data is still in use
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = rd_ptr_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        if (chk_vld_q && ffz_found) begin
          mem_we    = 1'b1;
          mem_waddr = chk_addr_q;
          mem_wdata = mem_rdata | alloc_mask;
        end
      end
      ST_BIT_RD: begin
        mem_raddr = bit_addr_q;
      end
      ST_BIT_OP: begin
        mem_waddr = bit_addr_q;
        if (act_q == bba_pkg::ACT_FREE) begin
          mem_we    = cur_bit;
          mem_wdata = mem_rdata & ~bit_mask;
        end else if (act_q == bba_pkg::ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = bv_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      init_q     <= 1'b0;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= bba_pkg::STATUS_OK;
      res_q      <= '0;
      rdbit_q    <= 1'b0;
      act_q      <= bba_pkg::ACT_INIT;
      idx_q      <= '0;
      bv_q       <= 1'b0;
      bit_addr_q <= '0;
      bit_off_q  <= '0;
      rd_ptr_q   <= '0;
      chk_addr_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NWORDS - 1)) begin
            state_q <= ST_IDLE;
            init_q  <= 1'b0;
            if (init_q) begin
              done_q   <= 1'b1;
              status_q <= bba_pkg::STATUS_OK;
              res_q    <= '0;
              rdbit_q  <= 1'b0;
            end
          end
        end

        ST_IDLE: begin
          if (start) begin
            act_q      <= action_i;
            idx_q      <= block_index_i;
            bv_q       <= bit_value_i;
            bit_addr_q <= idx_ext[LW +: AW];
            bit_off_q  <= idx_ext[LW-1:0];
            res_q      <= '0;
            rdbit_q    <= 1'b0;
            status_q   <= bba_pkg::STATUS_OK;
            case (action_i)
              bba_pkg::ACT_INIT: begin
                cnt_q   <= has_room ? (size - CW'(fdb_q)) : '0;
                clr_q   <= '0;
                init_q  <= 1'b1;
                state_q <= ST_CLEAR;
              end
              bba_pkg::ACT_ALLOC: begin
                if ((cnt_q == '0) || !has_room) begin
                  done_q   <= 1'b1;
                  status_q <= bba_pkg::STATUS_NO_FREE;
                end else begin
                  rd_ptr_q  <= lo_w;
                  chk_vld_q <= 1'b0;
                  state_q   <= ST_SCAN;
                end
              end
              bba_pkg::ACT_FREE, bba_pkg::ACT_READ, bba_pkg::ACT_WRITE: begin
                if (!in_range) begin
                  done_q   <= 1'b1;
                  status_q <= bba_pkg::STATUS_RANGE;
                end else begin
                  state_q <= ST_BIT_RD;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // read one word ahead while checking the one that just came back
          rd_ptr_q   <= rd_ptr_q + AW'(1);
          chk_addr_q <= rd_ptr_q;
          chk_vld_q  <= 1'b1;
          if (chk_vld_q) begin
            if (ffz_found) begin
              cnt_q    <= cnt_q - CW'(1);
              done_q   <= 1'b1;
              status_q <= bba_pkg::STATUS_OK;
              res_q    <= alloc_blk[bba_pkg::BLK_W-1:0];
              state_q  <= ST_IDLE;
            end else if (chk_addr_q == hi_w) begin
              done_q   <= 1'b1;
              status_q <= bba_pkg::STATUS_NO_FREE;
              state_q  <= ST_IDLE;
            end
          end
        end

        ST_BIT_RD: begin
          state_q <= ST_BIT_OP;
        end

        ST_BIT_OP: begin
          state_q  <= ST_IDLE;
          done_q   <= 1'b1;
          status_q <= bba_pkg::STATUS_OK;
          case (act_q)
            bba_pkg::ACT_FREE: begin
              res_q <= idx_q;
              if (cur_bit && (cnt_q != bba_pkg::COUNT_MAX)) begin
                cnt_q <= cnt_q + CW'(1);
              end
            end
            bba_pkg::ACT_READ: begin
              rdbit_q <= cur_bit;
            end
            default: ;
          endcase
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_block_o = res_q;
  assign bit_read_o     = rdbit_q;
  assign free_blocks_o  = cnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_range_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == bba_pkg::STATUS_RANGE)) |->
      ((result_block_o == '0) && !bit_read_o))
    else $error("out-of-range result carries data");

  a_scan_needs_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q != '0))
    else $error("scan running with zero free count");

  a_alloc_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && start && (action_i == bba_pkg::ACT_ALLOC) &&
     (cnt_q == '0)) |=> (done_o && (status_o == bba_pkg::STATUS_NO_FREE)))
    else $error("allocate with empty count did not fail at once");

  a_alloc_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && chk_vld_q && ffz_found) |=>
      (cnt_q == ($past(cnt_q) - CW'(1))))
    else $error("allocation did not decrement the free count");

endmodule

`default_nettype wire
